>>> rtl/core/cws_pkg.sv
// Shared constants, types and helpers for the command line word splitter.
package cws_pkg;

  localparam int RUN_MAX = 32;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);
  localparam int IDX_W   = $clog2(RUN_MAX);

  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] WORDS_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ITEM_END,
    ITEM_BLANK,
    ITEM_BSL,
    ITEM_DQ,
    ITEM_CHAR
  } item_e;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EOW   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLANKS,
    ST_SEP,
    ST_BSL,
    ST_TAIL
  } state_e;

  typedef struct packed {
    logic load;
    logic emit_blank;
    logic emit_sep;
    logic emit_bsl;
    logic tail;
  } cmd_t;

  typedef struct packed {
    item_e in_cls;
    logic  blanks_nz;
    logic  sep_pending;
    logic  bload_nz;
    logic  bcnt_nz;
    logic  bcnt_last;
    logic  idx_last;
    logic  out_free;
    logic  tail_out;
  } sts_t;

  function automatic item_e classify(logic is_end, logic [7:0] ch);
    item_e cls;
    if (is_end) begin
      cls = ITEM_END;
    end else if (ch == CH_SP || ch == CH_TAB) begin
      cls = ITEM_BLANK;
    end else if (ch == CH_BSL) begin
      cls = ITEM_BSL;
    end else if (ch == CH_DQ) begin
      cls = ITEM_DQ;
    end else begin
      cls = ITEM_CHAR;
    end
    return cls;
  endfunction

endpackage

>>> rtl/core/cws_in_if.sv
// Input word channel: one command line byte or the end marker.
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_end;

  modport source (output valid, output char_in, output is_end, input ready);
  modport sink   (input valid, input char_in, input is_end, output ready);
endinterface

>>> rtl/core/cws_out_if.sv
// Output word channel: one splitter result.
interface cws_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [7:0] word_count;
  logic       run_overflow;
  logic       last;

  modport source (output valid, output kind, output char_out, output word_count,
                  output run_overflow, output last, input ready);
  modport sink   (input valid, input kind, input char_out, input word_count,
                  input run_overflow, input last, output ready);
endinterface

>>> rtl/core/cws_ctrl.sv
// Sequencer: walks each accepted byte through blank, separator, backslash and tail phases.
module cws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cws_pkg::sts_t sts_i,
  output cws_pkg::cmd_t cmd_o
);

  cws_pkg::state_e state_q, state_d;
  logic tail_go;
  logic word_item;

  assign tail_go   = !sts_i.tail_out || sts_i.out_free;
  assign word_item = (sts_i.in_cls != cws_pkg::ITEM_END) &&
                     (sts_i.in_cls != cws_pkg::ITEM_BLANK);

  always_comb begin
    state_d = state_q;
    case (state_q)
      cws_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (word_item && sts_i.blanks_nz) begin
            state_d = cws_pkg::ST_BLANKS;
          end else if (word_item && sts_i.sep_pending) begin
            state_d = cws_pkg::ST_SEP;
          end else if (sts_i.bload_nz) begin
            state_d = cws_pkg::ST_BSL;
          end else begin
            state_d = cws_pkg::ST_TAIL;
          end
        end
      end
      cws_pkg::ST_BLANKS: begin
        if (sts_i.out_free && sts_i.idx_last) begin
          if (sts_i.sep_pending) begin
            state_d = cws_pkg::ST_SEP;
          end else if (sts_i.bcnt_nz) begin
            state_d = cws_pkg::ST_BSL;
          end else begin
            state_d = cws_pkg::ST_TAIL;
          end
        end
      end
      cws_pkg::ST_SEP: begin
        if (sts_i.out_free) begin
          state_d = sts_i.bcnt_nz ? cws_pkg::ST_BSL : cws_pkg::ST_TAIL;
        end
      end
      cws_pkg::ST_BSL: begin
        if (sts_i.out_free && sts_i.bcnt_last) begin
          state_d = cws_pkg::ST_TAIL;
        end
      end
      cws_pkg::ST_TAIL: begin
        if (tail_go) begin
          state_d = cws_pkg::ST_IDLE;
        end
      end
      default: state_d = cws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == cws_pkg::ST_IDLE);
    cmd_o.load       = (state_q == cws_pkg::ST_IDLE) && in_valid_i;
    cmd_o.emit_blank = (state_q == cws_pkg::ST_BLANKS) && sts_i.out_free;
    cmd_o.emit_sep   = (state_q == cws_pkg::ST_SEP) && sts_i.out_free;
    cmd_o.emit_bsl   = (state_q == cws_pkg::ST_BSL) && sts_i.out_free;
    cmd_o.tail       = (state_q == cws_pkg::ST_TAIL) && tail_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cws_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/cws_dpath.sv
// Datapath: splitter state, held blank store, item latch and output register.
module cws_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_char_i,
  input  logic          in_is_end_i,
  input  cws_pkg::cmd_t cmd_i,
  output cws_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_char_o,
  output logic [7:0]    out_words_o,
  output logic          out_ovf_o,
  output logic          out_last_o
);

  localparam logic [cws_pkg::RUN_W-1:0] RunMax = cws_pkg::RUN_W'(cws_pkg::RUN_MAX);
  localparam logic [cws_pkg::RUN_W-1:0] RunOne = cws_pkg::RUN_W'(1);

  logic                      seen_q, seen_d;
  logic                      inq_q, inq_d;
  logic                      sep_q, sep_d;
  logic [cws_pkg::RUN_W-1:0] bsl_q, bsl_d;
  logic [cws_pkg::RUN_W-1:0] blen_q, blen_d;
  logic [7:0]                words_q, words_d;
  logic                      ovf_q, ovf_d;
  cws_pkg::item_e            cls_q, cls_d;
  logic [7:0]                char_q, char_d;
  logic [cws_pkg::RUN_W-1:0] bcnt_q, bcnt_d;
  logic [cws_pkg::IDX_W-1:0] idx_q, idx_d;

  logic                      ovalid_q, ovalid_d;
  cws_pkg::kind_e            okind_q, okind_d;
  logic [7:0]                ochar_q, ochar_d;
  logic [7:0]                owords_q, owords_d;
  logic                      oovf_q, oovf_d;
  logic                      olast_q, olast_d;
  logic                      emit;

  logic                      tab_mem [cws_pkg::RUN_MAX];
  logic                      mem_we;
  logic                      tab_rd_q;

  cws_pkg::item_e            in_cls;
  logic [cws_pkg::RUN_W-1:0] bload;
  logic [7:0]                words_inc;
  logic                      out_free;

  assign in_cls    = cws_pkg::classify(in_is_end_i, in_char_i);
  assign words_inc = (words_q == cws_pkg::WORDS_MAX) ? words_q : words_q + 8'd1;
  assign out_free  = !ovalid_q || out_ready_i;

  always_comb begin
    case (in_cls)
      cws_pkg::ITEM_BLANK: bload = seen_q ? bsl_q : '0;
      cws_pkg::ITEM_BSL:   bload = '0;
      cws_pkg::ITEM_DQ:    bload = bsl_q >> 1;
      default:             bload = bsl_q;
    endcase
  end

  always_comb begin
    sts_o.in_cls      = in_cls;
    sts_o.blanks_nz   = (blen_q != '0);
    sts_o.sep_pending = sep_q;
    sts_o.bload_nz    = (bload != '0);
    sts_o.bcnt_nz     = (bcnt_q != '0);
    sts_o.bcnt_last   = (bcnt_q == RunOne);
    sts_o.idx_last    = (cws_pkg::RUN_W'(idx_q) + RunOne == blen_q);
    sts_o.out_free    = out_free;
    case (cls_q)
      cws_pkg::ITEM_END:  sts_o.tail_out = 1'b1;
      cws_pkg::ITEM_CHAR: sts_o.tail_out = 1'b1;
      cws_pkg::ITEM_DQ:   sts_o.tail_out = bsl_q[0];
      default:            sts_o.tail_out = 1'b0;
    endcase
  end

  always_comb begin
    seen_d   = seen_q;
    inq_d    = inq_q;
    sep_d    = sep_q;
    bsl_d    = bsl_q;
    blen_d   = blen_q;
    words_d  = words_q;
    ovf_d    = ovf_q;
    cls_d    = cls_q;
    char_d   = char_q;
    bcnt_d   = bcnt_q;
    idx_d    = idx_q;
    emit     = 1'b0;
    okind_d  = cws_pkg::KIND_CHAR;
    ochar_d  = 8'd0;
    owords_d = words_q;
    oovf_d   = ovf_q;
    olast_d  = 1'b0;
    mem_we   = 1'b0;

    if (cmd_i.load) begin
      char_d = in_char_i;
      cls_d  = in_cls;
      bcnt_d = bload;
      idx_d  = '0;
    end

    if (cmd_i.emit_blank) begin
      idx_d   = idx_q + 1'b1;
      emit    = 1'b1;
      ochar_d = tab_rd_q ? cws_pkg::CH_TAB : cws_pkg::CH_SP;
    end

    if (cmd_i.emit_sep) begin
      sep_d    = 1'b0;
      words_d  = words_inc;
      emit     = 1'b1;
      okind_d  = cws_pkg::KIND_EOW;
      owords_d = words_inc;
    end

    if (cmd_i.emit_bsl) begin
      bcnt_d  = bcnt_q - RunOne;
      emit    = 1'b1;
      ochar_d = cws_pkg::CH_BSL;
    end

    if (cmd_i.tail) begin
      case (cls_q)
        cws_pkg::ITEM_END: begin
          emit     = 1'b1;
          olast_d  = 1'b1;
          okind_d  = seen_q ? cws_pkg::KIND_EOW : cws_pkg::KIND_EMPTY;
          owords_d = seen_q ? words_inc : words_q;
          seen_d   = 1'b0;
          inq_d    = 1'b0;
          sep_d    = 1'b0;
          bsl_d    = '0;
          blen_d   = '0;
          words_d  = '0;
          ovf_d    = 1'b0;
        end
        cws_pkg::ITEM_BLANK: begin
          if (seen_q) begin
            bsl_d = '0;
            if (!inq_q) begin
              sep_d = 1'b1;
            end else if (blen_q < RunMax) begin
              mem_we = 1'b1;
              blen_d = blen_q + RunOne;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        cws_pkg::ITEM_BSL: begin
          seen_d = 1'b1;
          blen_d = '0;
          if (bsl_q < RunMax) begin
            bsl_d = bsl_q + RunOne;
          end else begin
            ovf_d = 1'b1;
          end
        end
        cws_pkg::ITEM_DQ: begin
          seen_d = 1'b1;
          blen_d = '0;
          bsl_d  = '0;
          if (bsl_q[0]) begin
            emit    = 1'b1;
            ochar_d = cws_pkg::CH_DQ;
          end else begin
            inq_d = !inq_q;
          end
        end
        default: begin
          seen_d  = 1'b1;
          blen_d  = '0;
          bsl_d   = '0;
          emit    = 1'b1;
          ochar_d = char_q;
        end
      endcase
    end

    ovalid_d = emit || (ovalid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      inq_q    <= 1'b0;
      sep_q    <= 1'b0;
      bsl_q    <= '0;
      blen_q   <= '0;
      words_q  <= '0;
      ovf_q    <= 1'b0;
      cls_q    <= cws_pkg::ITEM_CHAR;
      bcnt_q   <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      seen_q   <= seen_d;
      inq_q    <= inq_d;
      sep_q    <= sep_d;
      bsl_q    <= bsl_d;
      blen_q   <= blen_d;
      words_q  <= words_d;
      ovf_q    <= ovf_d;
      cls_q    <= cls_d;
      bcnt_q   <= bcnt_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (emit) begin
      okind_q  <= okind_d;
      ochar_q  <= ochar_d;
      owords_q <= owords_d;
      oovf_q   <= oovf_d;
      olast_q  <= olast_d;
    end
  end

  // registered read at the next index; writes only happen in tail cycles
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tab_mem[blen_q[cws_pkg::IDX_W-1:0]] <= (char_q == cws_pkg::CH_TAB);
    end
    tab_rd_q <= tab_mem[idx_d];
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = okind_q;
  assign out_char_o  = ochar_q;
  assign out_words_o = owords_q;
  assign out_ovf_o   = oovf_q;
  assign out_last_o  = olast_q;

endmodule

>>> rtl/core/command_line_word_splitter_top.sv
// Top level of the command line word splitter: sequencer, datapath and channel wiring.
//
//   channel  dir  payload                                      word
//   in_i     in   char_in[8], is_end                            one byte or end marker
//   out_o    out  kind[2], char_out[8], word_count[8],          one result
//                 run_overflow, last
//
// An item is loaded, then releases any blank, separator or backslash results
// before its own tail; the tail cycle carries its own result, if any.
// The emit sequencer in cws_ctrl produces at most one result per cycle.
// Reset is asynchronous, active low, and returns the splitter to line start.
// A stalled output holds the sequencer; input is taken only between items.
module command_line_word_splitter_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  cws_in_if.sink           in_i,
  cws_out_if.source        out_o
);

  cws_pkg::cmd_t cmd;
  cws_pkg::sts_t sts;
  logic          in_ready;

  cws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cws_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_char_i   (in_i.char_in),
    .in_is_end_i (in_i.is_end),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_kind_o  (out_o.kind),
    .out_char_o  (out_o.char_out),
    .out_words_o (out_o.word_count),
    .out_ovf_o   (out_o.run_overflow),
    .out_last_o  (out_o.last)
  );

  assign in_i.ready = in_ready;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input ready right after an accepted word");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |->
      (out_o.kind == cws_pkg::KIND_EOW) || (out_o.kind == cws_pkg::KIND_EMPTY))
    else $error("final result is a word character");

  a_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == cws_pkg::KIND_EMPTY) |->
      (out_o.word_count == 8'd0) && out_o.last)
    else $error("empty line result with words counted or not final");

endmodule
